FILE: rtl/core/owsp_pkg.sv
package owsp_pkg;

  // scratchpad geometry
  localparam int PAD_BITS = 64;
  localparam int CRC_CNT_W = $clog2(PAD_BITS);
  localparam int DIV_BITS = 16;
  localparam int DIV_CNT_W = $clog2(DIV_BITS);

  // 1-wire crc-8, reflected polynomial x^8+x^5+x^4+1
  localparam logic [7:0] CRC_POLY = 8'h8C;

  // family code that uses count-remain interpolation
  localparam logic [7:0] FAMILY_COUNT_REMAIN = 8'h10;

  // resolution field, byte 4 bits 6:5
  localparam logic [1:0] RES_9BIT  = 2'b00;
  localparam logic [1:0] RES_10BIT = 2'b01;
  localparam logic [1:0] RES_11BIT = 2'b10;
  localparam logic [1:0] RES_12BIT = 2'b11;

  // interpolation offset, a quarter degree in 1/128 units
  localparam logic [15:0] QUARTER_DEGREE = 16'd32;

  // error limit after reset
  localparam logic [7:0] ERROR_LIMIT_RESET = 8'd10;
  localparam logic [7:0] ERROR_COUNT_MAX = 8'hFF;

  // result status codes
  localparam logic [1:0] STATUS_VALID  = 2'd0;
  localparam logic [1:0] STATUS_RETRY  = 2'd1;
  localparam logic [1:0] STATUS_RESCAN = 2'd2;

  // status of a serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

FILE: rtl/core/owsp_crc8_serial.sv
module owsp_crc8_serial (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [63:0]                 data,
  output logic [7:0]                  crc,
  output owsp_pkg::unit_stat_t        stat
);
  import owsp_pkg::*;

  logic [PAD_BITS-1:0]  shreg;
  logic [CRC_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic                 fb;
  logic [7:0]           crc_next;

  // one data bit into the crc per cycle, lsb first
  always_comb begin
    fb = shreg[0] ^ crc[0];
    crc_next = (crc >> 1) ^ (fb ? CRC_POLY : 8'h00);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CRC_CNT_W'(PAD_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift register and crc
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= data;
      crc <= 8'h00;
    end else if (busy) begin
      shreg <= shreg >> 1;
      crc <= crc_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: rtl/core/owsp_div_serial.sv
module owsp_div_serial (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [15:0]                 dividend,
  input  logic [7:0]                  divisor,
  output logic [15:0]                 quotient,
  output owsp_pkg::unit_stat_t        stat
);
  import owsp_pkg::*;

  logic [7:0]           rem;
  logic [7:0]           dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [8:0]           trial;
  logic [9:0]           diff;
  logic                 ge;

  // restoring step: one quotient bit per cycle
  always_comb begin
    trial = {rem, quotient[DIV_BITS-1]};
    diff = {1'b0, trial} - {2'b00, dvs};
    ge = ~diff[9];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= 8'h00;
      dvs <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[7:0] : trial[7:0];
      quotient <= {quotient[DIV_BITS-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: rtl/core/onewire_scratchpad_temp_decoder.sv
// 1-wire temperature scratchpad decoder
//
// input channel s_axis: one item per sensor read. tdata carries the eight
// scratchpad bytes and the received crc byte, tuser the family code and the
// round-start flag. output channel m_axis: one item per input item, with the
// temperature in 1/128 degree in tdata and the status code in tuser
// (0 valid, 1 crc mismatch, 2 error limit exceeded); temperature is 0
// unless the status is valid.
// configuration: cfg_wr_en writes cfg_wr_data into the error limit.
//
// after acceptance the crc is computed one bit per clock over 64 bits,
// and the 16-bit interpolation divide runs one quotient bit per clock in
// parallel with it; the result is registered when both are done and the output register is free.
// s_axis_tready is high only while no item is in work, so one item is
// processed at a time. if the receiver stalls, the result waits in the
// output register and the next item may be accepted; its result is held
// until the register frees.
// reset clears the error count, sets the error limit to 10 and empties the
// output register.
module onewire_scratchpad_temp_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // pad_bytes[63:0], pad_crc[71:64]
  input  logic [8:0]  s_axis_tuser,   // family_code[7:0], new_round[8]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // temperature[15:0]
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import owsp_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]  state;
  logic [1:0]  state_next;
  logic [7:0]  error_limit;
  logic [7:0]  error_count;
  logic [7:0]  error_count_next;

  // latched item fields
  logic [7:0]  family;
  logic [15:0] raw;
  logic [1:0]  res_bits;
  logic [7:0]  byte7;
  logic [7:0]  rx_crc;
  logic        new_round;

  logic        accept;
  logic        finish;
  logic [8:0]  bdiff;
  logic [7:0]  crc;
  logic [15:0] quotient;
  logic [15:0] dt;
  logic [15:0] raw_masked;
  logic [15:0] temp;
  logic [7:0]  count_base;
  logic [1:0]  status;
  unit_stat_t  crc_stat;
  unit_stat_t  div_stat;

  assign accept = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign finish = (state == ST_FINISH) & ~div_stat.busy & (~m_axis_tvalid | m_axis_tready);

  // (b7 - b6) * 128, kept to 16 bits
  assign bdiff = {1'b0, s_axis_tdata[63:56]} - {1'b0, s_axis_tdata[55:48]};

  owsp_crc8_serial u_crc (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .data  (s_axis_tdata[63:0]),
    .crc   (crc),
    .stat  (crc_stat)
  );

  owsp_div_serial u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend ({bdiff, 7'b0}),
    .divisor  (s_axis_tdata[63:56]),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_RUN;
      ST_RUN:    if (crc_stat.done) state_next = ST_FINISH;
      ST_FINISH: if (finish) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // temperature decode
  always_comb begin
    dt = (byte7 == 8'h00) ? 16'h0000 : quotient;
    case (res_bits)
      RES_9BIT:  raw_masked = {raw[15:3], 3'b000};
      RES_10BIT: raw_masked = {raw[15:2], 2'b00};
      RES_11BIT: raw_masked = {raw[15:1], 1'b0};
      default:   raw_masked = raw;
    endcase
    if (family == FAMILY_COUNT_REMAIN) begin
      temp = {raw[9:1], 7'b0} - QUARTER_DEGREE + dt;
    end else begin
      temp = {raw_masked[12:0], 3'b000};
    end
  end

  // error count and status
  always_comb begin
    count_base = new_round ? 8'h00 : error_count;
    if (crc != rx_crc) begin
      error_count_next = (count_base == ERROR_COUNT_MAX) ? count_base : count_base + 1'b1;
      status = (error_count_next > error_limit) ? STATUS_RESCAN : STATUS_RETRY;
    end else begin
      error_count_next = 8'h00;
      status = STATUS_VALID;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      error_limit <= ERROR_LIMIT_RESET;
      error_count <= 8'h00;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        error_limit <= cfg_wr_data;
      end
      if (finish) begin
        error_count <= error_count_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // item fields and output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      family <= s_axis_tuser[7:0];
      new_round <= s_axis_tuser[8];
      raw <= s_axis_tdata[15:0];
      res_bits <= s_axis_tdata[38:37];
      byte7 <= s_axis_tdata[63:56];
      rx_crc <= s_axis_tdata[71:64];
    end
    if (finish) begin
      m_axis_tdata <= (status == STATUS_VALID) ? temp : 16'h0000;
      m_axis_tuser <= status;
    end
  end

endmodule

FILE: rtl/core/owsp_checker.sv
module owsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import owsp_pkg::*;

  // status is one of the three codes
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == STATUS_VALID || m_axis_tuser == STATUS_RETRY ||
                       m_axis_tuser == STATUS_RESCAN))
    else $error("bad status code");

  // failed reads carry no temperature
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != STATUS_VALID) |-> (m_axis_tdata == 16'h0000))
    else $error("temperature not zero on error");

  // one item in work at a time
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("item accepted while busy");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind onewire_scratchpad_temp_decoder owsp_checker u_owsp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: dv/onewire_scratchpad_temp_decoder_tb.sv
`timescale 1ns / 100ps

module onewire_scratchpad_temp_decoder_tb;
  import owsp_pkg::*;

  // family codes used by the stimulus
  localparam logic [7:0] FAMILY_12BIT = 8'h28;
  localparam logic [7:0] FAMILY_PROG  = 8'h22;

  // how a table row gets its crc byte
  typedef enum logic [1:0] {
    CRC_OK,
    CRC_FLIP,
    CRC_AS_IS
  } crc_kind_t;

  typedef struct packed {
    logic [7:0]  family;
    logic [63:0] pad;
    logic [7:0]  crc;
    logic        new_round;
  } sensor_read_t;

  typedef struct packed {
    logic [15:0] temp;
    logic [1:0]  status;
  } temp_result_t;

  typedef struct packed {
    logic [7:0]  family;
    logic [63:0] pad;
    crc_kind_t   crc_kind;
    logic [7:0]  crc;
    logic        new_round;
    logic        typed;
    logic [15:0] exp_temp;
    logic [1:0]  exp_status;
  } read_row_t;

  localparam int N_ROWS = 23;

  // directed reads, run at the reset error limit of 10
  read_row_t read_tab [0:N_ROWS-1] = '{
    // all-zero pad with its crc of zero
    '{FAMILY_12BIT, 64'h0, CRC_AS_IS, 8'h00, 1'b0, 1'b1, 16'h0000, STATUS_VALID},
    // count-remain with zero divisor: 0 * 64 - 32
    '{FAMILY_COUNT_REMAIN, 64'h0, CRC_AS_IS, 8'h00, 1'b0, 1'b1, 16'hFFE0, STATUS_VALID},
    '{FAMILY_12BIT, 64'hFFFF_FFFF_FFFF_FFFF, CRC_OK, 8'h00, 1'b0, 1'b0, 16'h0, STATUS_VALID},
    '{FAMILY_COUNT_REMAIN, 64'hFFFF_FFFF_FFFF_FFFF, CRC_OK, 8'h00, 1'b0, 1'b0, 16'h0,
      STATUS_VALID},
    '{FAMILY_COUNT_REMAIN, 64'h100C_FFFF_464B_0032, CRC_OK, 8'h00, 1'b0, 1'b0, 16'h0,
      STATUS_VALID},
    // remain above count per degree, difference wraps
    '{FAMILY_COUNT_REMAIN, 64'h1020_FFFF_464B_FFCE, CRC_OK, 8'h00, 1'b0, 1'b0, 16'h0,
      STATUS_VALID},
    '{FAMILY_COUNT_REMAIN, 64'h0100_0000_0000_00AA, CRC_OK, 8'h00, 1'b0, 1'b0, 16'h0,
      STATUS_VALID},
    '{FAMILY_COUNT_REMAIN, 64'hFF00_0000_0000_0001, CRC_OK, 8'h00, 1'b0, 1'b0, 16'h0,
      STATUS_VALID},
    // zero divisor with a nonzero reading
    '{FAMILY_COUNT_REMAIN, 64'h00FF_0000_0000_7FFF, CRC_OK, 8'h00, 1'b0, 1'b0, 16'h0,
      STATUS_VALID},
    // the four resolutions
    '{FAMILY_12BIT, 64'h0000_001F_0000_07FF, CRC_OK, 8'h00, 1'b0, 1'b0, 16'h0, STATUS_VALID},
    '{FAMILY_12BIT, 64'h0000_003F_0000_07FF, CRC_OK, 8'h00, 1'b0, 1'b0, 16'h0, STATUS_VALID},
    '{FAMILY_12BIT, 64'h0000_005F_0000_FC97, CRC_OK, 8'h00, 1'b0, 1'b0, 16'h0, STATUS_VALID},
    '{FAMILY_12BIT, 64'h0000_007F_0000_FC97, CRC_OK, 8'h00, 1'b0, 1'b0, 16'h0, STATUS_VALID},
    // most negative raw reading wraps at 16 bits
    '{FAMILY_PROG, 64'h0000_007F_0000_8000, CRC_OK, 8'h00, 1'b0, 1'b0, 16'h0, STATUS_VALID},
    '{8'hFF, 64'h5A3C_9600_E1D2_4B87, CRC_OK, 8'h00, 1'b0, 1'b0, 16'h0, STATUS_VALID},
    '{8'h00, 64'hA5C3_69FF_1E2D_B478, CRC_OK, 8'h00, 1'b1, 1'b0, 16'h0, STATUS_VALID},
    // crc mismatches below the limit
    '{FAMILY_12BIT, 64'h0, CRC_AS_IS, 8'hFF, 1'b0, 1'b1, 16'h0000, STATUS_RETRY},
    '{FAMILY_12BIT, 64'h0, CRC_AS_IS, 8'h01, 1'b0, 1'b1, 16'h0000, STATUS_RETRY},
    '{FAMILY_COUNT_REMAIN, 64'h0, CRC_AS_IS, 8'h80, 1'b0, 1'b1, 16'h0000, STATUS_RETRY},
    // a match clears the count
    '{FAMILY_12BIT, 64'h0, CRC_AS_IS, 8'h00, 1'b0, 1'b1, 16'h0000, STATUS_VALID},
    '{FAMILY_12BIT, 64'h0, CRC_AS_IS, 8'h55, 1'b1, 1'b1, 16'h0000, STATUS_RETRY},
    '{FAMILY_12BIT, 64'h0, CRC_AS_IS, 8'h00, 1'b1, 1'b1, 16'h0000, STATUS_VALID},
    '{FAMILY_12BIT, 64'h1234_5678_9ABC_DEF0, CRC_FLIP, 8'h00, 1'b0, 1'b1, 16'h0000,
      STATUS_RETRY}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // pad_bytes[63:0], pad_crc[71:64]
  logic [8:0]  s_axis_tuser = '0;   // family_code[7:0], new_round[8]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // temperature[15:0]
  logic [1:0]  m_axis_tuser;        // status[1:0]
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  // predictor state
  logic [7:0]   crc_err_count = '0;
  logic [7:0]   err_limit = ERROR_LIMIT_RESET;
  temp_result_t pending_temps [$];

  int mismatches = 0;
  int n_reads = 0;
  int n_valid = 0;
  int n_retry = 0;
  int n_rescan = 0;
  int burst_left = 0;
  int rx_tick = 0;
  int rx_mode = 0;

  onewire_scratchpad_temp_decoder u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // 1-wire crc-8, lsb first
  function automatic logic [7:0] crc8_of(logic [63:0] pad);
    logic [7:0] crc;
    logic       fb;
    crc = '0;
    for (int i = 0; i < 64; i++) begin
      fb = pad[i] ^ crc[0];
      crc = crc >> 1;
      if (fb) crc = crc ^ CRC_POLY;
    end
    return crc;
  endfunction

  // temperature in 1/128 degree from a scratchpad that passed its crc
  function automatic logic [15:0] temp_of(logic [7:0] family, logic [63:0] pad);
    logic [15:0] raw;
    logic [15:0] diff;
    logic [15:0] frac;
    logic [7:0]  remain;
    logic [7:0]  per_degree;
    raw = pad[15:0];
    remain = pad[55:48];
    per_degree = pad[63:56];
    if (family == FAMILY_COUNT_REMAIN) begin
      diff = {8'h00, per_degree} - {8'h00, remain};
      diff = diff << 7;
      frac = (per_degree != 8'h00) ? diff / {8'h00, per_degree} : 16'h0000;
      return {raw[15:1], 1'b0} * 16'd64 - QUARTER_DEGREE + frac;
    end
    case (pad[38:37])
      RES_9BIT:  raw[2:0] = 3'b000;
      RES_10BIT: raw[1:0] = 2'b00;
      RES_11BIT: raw[0] = 1'b0;
      default: ;
    endcase
    return raw << 3;
  endfunction

  // updates the error count (up on a mismatch, cleared on a match) and returns the result of one read
  function automatic temp_result_t decode_read(sensor_read_t rd);
    temp_result_t r;
    if (rd.new_round) crc_err_count = '0;
    if (crc8_of(rd.pad) != rd.crc) begin
      if (crc_err_count != ERROR_COUNT_MAX) crc_err_count = crc_err_count + 8'd1;
      r.temp = '0;
      r.status = (crc_err_count > err_limit) ? STATUS_RESCAN : STATUS_RETRY;
    end else begin
      crc_err_count = '0;
      r.temp = temp_of(rd.family, rd.pad);
      r.status = STATUS_VALID;
    end
    return r;
  endfunction

  // random read, well formed but for a given share of bad crc bytes
  function automatic sensor_read_t random_read(int bad_pct, int round_pct);
    sensor_read_t rd;
    rd.pad = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0, 1: rd.family = FAMILY_COUNT_REMAIN;
      2: rd.family = FAMILY_12BIT;
      default: rd.family = 8'($urandom);
    endcase
    // count per degree: the usual 16, tiny and zero divisors, or anything
    if (rd.family == FAMILY_COUNT_REMAIN) begin
      case ($urandom_range(0, 3))
        0: rd.pad[63:56] = 8'h10;
        1: rd.pad[63:56] = 8'($urandom_range(0, 3));
        default: ;
      endcase
    end
    rd.crc = crc8_of(rd.pad);
    if ($urandom_range(0, 99) < bad_pct) rd.crc = rd.crc ^ 8'($urandom_range(1, 255));
    rd.new_round = ($urandom_range(0, 99) < round_pct);
    return rd;
  endfunction

  // push one read through the input channel, in bursts with gaps
  task automatic send_read(sensor_read_t rd, logic typed, temp_result_t typed_res);
    int gap;
    temp_result_t pred;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {rd.crc, rd.pad};
    s_axis_tuser <= {rd.new_round, rd.family};
    do @(posedge clk); while (!s_axis_tready);
    // the error count is updated on every read, typed or not
    pred = decode_read(rd);
    pending_temps.push_back(typed ? typed_res : pred);
    n_reads++;
  endtask

  task automatic run_reads(int count, int bad_pct, int round_pct);
    for (int i = 0; i < count; i++) send_read(random_read(bad_pct, round_pct), 1'b0, '0);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_temps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_error_limit(logic [7:0] limit);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= limit;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    err_limit = limit;
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    temp_result_t got;
    temp_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata, m_axis_tuser};
      case (got.status)
        STATUS_VALID: n_valid++;
        STATUS_RETRY: n_retry++;
        default: n_rescan++;
      endcase
      if (pending_temps.size() == 0) begin
        $error("result with no read pending: temperature %0d status %0d",
               $signed(got.temp), got.status);
        mismatches++;
      end else begin
        want = pending_temps.pop_front();
        if (got.temp !== want.temp) begin
          $error("temperature: expected %0d, got %0d", $signed(want.temp), $signed(got.temp));
          mismatches++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          mismatches++;
        end
      end
    end
    rx_tick++;
    if (rx_tick % 256 == 0) rx_mode = $urandom_range(0, 2);
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ((rx_tick % 32) >= 21);
    endcase
  end

  initial begin
    sensor_read_t rd;
    temp_result_t typed_res;
    logic [7:0]   rand_limit;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int k = 0; k < N_ROWS; k++) begin
      rd.family = read_tab[k].family;
      rd.pad = read_tab[k].pad;
      rd.new_round = read_tab[k].new_round;
      case (read_tab[k].crc_kind)
        CRC_OK: rd.crc = crc8_of(rd.pad);
        CRC_FLIP: rd.crc = crc8_of(rd.pad) ^ 8'hA5;
        default: rd.crc = read_tab[k].crc;
      endcase
      typed_res = {read_tab[k].exp_temp, read_tab[k].exp_status};
      send_read(rd, read_tab[k].typed, typed_res);
    end
    s_axis_tvalid <= 1'b0;

    // rescan on the first mismatch
    write_error_limit(8'd0);
    run_reads(80, 50, 10);

    write_error_limit(8'd5);
    run_reads(120, 40, 5);

    // long mismatch streak drives the count into saturation
    write_error_limit(8'd254);
    run_reads(40, 30, 10);
    run_reads(270, 100, 0);

    // a limit of 255 never asks for a rescan
    write_error_limit(8'd255);
    run_reads(80, 100, 0);

    rand_limit = 8'($urandom_range(1, 253));
    write_error_limit(rand_limit);
    run_reads(100, 25, 10);

    // drain and let any stray result show up
    while (pending_temps.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("%0d sensor reads decoded: %0d valid, %0d retry, %0d rescan",
             n_reads, n_valid, n_retry, n_rescan);
    $display("error limits used: 10, 0, 5, 254, 255 and %0d", rand_limit);
    if (mismatches == 0) begin
      $display("onewire_scratchpad_temp_decoder_tb OK");
    end else begin
      $display("onewire_scratchpad_temp_decoder_tb NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("onewire_scratchpad_temp_decoder_tb NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/owsp_pkg.sv
rtl/core/owsp_crc8_serial.sv
rtl/core/owsp_div_serial.sv
rtl/core/onewire_scratchpad_temp_decoder.sv
rtl/core/owsp_checker.sv
dv/onewire_scratchpad_temp_decoder_tb.sv
